// ===== design/mlfe_pkg.sv =====
// Shared types and constants for the modular level frame encoder.
// No dependencies; imported by every module of the block.
package mlfe_pkg;

    localparam int LEVEL_W   = 9;
    localparam int SYM_W     = 9;
    localparam int STEP_W    = 4;
    localparam int IDX_W     = 32;
    localparam int BSIZE_W   = 16;
    localparam int FLEN_W    = 32;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 32;

    // Level wraps modulo MAX_LEVEL + 1
    localparam logic [LEVEL_W:0] MAX_LEVEL = 10'd258;
    localparam logic [LEVEL_W:0] MODULUS   = MAX_LEVEL + 10'd1;

    localparam logic [SYM_W-1:0] SYM_START = 9'd257;
    localparam logic [SYM_W-1:0] SYM_END   = 9'd258;

    // Reset values of the registers
    localparam logic [BSIZE_W-1:0] BLOCK_SIZE_RST   = 16'd1024;
    localparam logic [FLEN_W-1:0]  FILE_LENGTH_RST  = 32'd1024;
    localparam logic [IDX_W-1:0]   TOTAL_BLOCKS_RST = 32'd1;

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_BLOCK_SIZE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FILE_LENGTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TOTAL_BLOCKS = 2'd2;

    // Symbol positions within one item's run of beats
    localparam logic [STEP_W-1:0] STEP_START = 4'd0;
    localparam logic [STEP_W-1:0] STEP_TOT0  = 4'd1;
    localparam logic [STEP_W-1:0] STEP_TOT3  = 4'd4;
    localparam logic [STEP_W-1:0] STEP_IDX0  = 4'd5;
    localparam logic [STEP_W-1:0] STEP_IDX3  = 4'd8;
    localparam logic [STEP_W-1:0] STEP_SZ0   = 4'd9;
    localparam logic [STEP_W-1:0] STEP_SZ3   = 4'd12;
    localparam logic [STEP_W-1:0] STEP_DATA  = 4'd13;
    localparam logic [STEP_W-1:0] STEP_END   = 4'd14;

    // One item as handed from the block bookkeeping to the emitter
    typedef struct packed {
        logic [7:0]         data;
        logic               hdr;     // block opens with this byte
        logic               ends;    // block closes with this byte
        logic [IDX_W-1:0]   total;
        logic [IDX_W-1:0]   index;
        logic [BSIZE_W-1:0] size;
    } item_t;

endpackage

// ===== design/modular_level_frame_encoder_top.sv =====
// Top level of the modular level frame encoder: configuration registers,
// block and file bookkeeping, and the symbol emitter. Uses mlfe_pkg, mlfe_emitter.

// Each input byte gives 1 to 15 output beats (start marker and 12-byte header
// when a block opens, the data symbol, the end marker when the block closes),
// the last one flagged by m_tlast. Beats leave at one per cycle, set by the
// single running-level adder, while m_tready stays high; the next byte is
// taken in the cycle its predecessor's last beat enters the output register.
// Register writes restart the pass (block number back to 1, file count
// reloaded) but keep the level; write them only while the block is idle.
module modular_level_frame_encoder_top
    import mlfe_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [7:0]           s_tdata,   // [7:0] data_byte
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [23:0]          m_tdata,   // [8:0] level, [17:9] symbol, rest zero
    output logic                 m_tlast,   // last_of_run
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_DAT_W-1:0] cfg_data
);

    logic [BSIZE_W-1:0] block_size_reg;
    logic [FLEN_W-1:0]  file_length_reg;
    logic [IDX_W-1:0]   total_blocks_reg;
    logic [IDX_W-1:0]   block_index_reg, block_index_next;
    logic [BSIZE_W-1:0] left_block_reg, left_block_next;
    logic [FLEN_W-1:0]  left_file_reg, left_file_next;

    logic               accept;
    logic               cfg_wr;
    logic               cfg_known;
    logic [FLEN_W-1:0]  new_len;
    logic [FLEN_W-1:0]  eff_len;
    logic [BSIZE_W-1:0] bs_eff;
    logic [IDX_W-1:0]   idx_cur;
    logic [BSIZE_W-1:0] lb_cur;
    logic [FLEN_W-1:0]  file_cur;
    logic [BSIZE_W-1:0] sz;
    logic [BSIZE_W-1:0] lb_start;
    logic [BSIZE_W-1:0] lb_after;
    logic [FLEN_W-1:0]  file_after;
    item_t              item;
    logic               take_ready;

    assign accept    = s_tvalid && take_ready;
    assign s_tready  = take_ready;
    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid;
    assign cfg_known = (cfg_index == REG_BLOCK_SIZE) || (cfg_index == REG_FILE_LENGTH)
                    || (cfg_index == REG_TOTAL_BLOCKS);

    // Effective lengths: zero acts as one
    assign eff_len = (file_length_reg == '0) ? FLEN_W'(1) : file_length_reg;
    assign new_len = (cfg_data == '0) ? FLEN_W'(1) : cfg_data;
    assign bs_eff  = (block_size_reg == '0) ? BSIZE_W'(1) : block_size_reg;

    // State seen by this byte (a drained file restarts the pass)
    always_comb begin
        if (left_file_reg == '0) begin
            idx_cur  = IDX_W'(1);
            lb_cur   = '0;
            file_cur = eff_len;
        end else begin
            idx_cur  = block_index_reg;
            lb_cur   = left_block_reg;
            file_cur = left_file_reg;
        end
    end

    // Block size for a new block: remainder of the file or a full block
    assign sz         = (file_cur < {16'd0, bs_eff}) ? file_cur[BSIZE_W-1:0] : bs_eff;
    assign lb_start   = (lb_cur == '0) ? sz : lb_cur;
    assign lb_after   = lb_start - 16'd1;
    assign file_after = file_cur - 32'd1;

    always_comb begin
        item.data  = s_tdata;
        item.hdr   = (lb_cur == '0);
        item.ends  = (lb_after == '0);
        item.total = total_blocks_reg;
        item.index = idx_cur;
        item.size  = sz;
    end

    // Bookkeeping update per accepted byte or register write
    always_comb begin
        block_index_next = block_index_reg;
        left_block_next  = left_block_reg;
        left_file_next   = left_file_reg;
        if (cfg_wr && cfg_known) begin
            block_index_next = IDX_W'(1);
            left_block_next  = '0;
            left_file_next   = (cfg_index == REG_FILE_LENGTH) ? new_len : eff_len;
        end else if (accept) begin
            left_block_next = lb_after;
            left_file_next  = file_after;
            block_index_next = idx_cur;
            if (lb_after == '0) begin
                block_index_next = idx_cur + 32'd1;
                if (file_after == '0) begin
                    block_index_next = IDX_W'(1);
                    left_file_next   = eff_len;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            block_size_reg   <= BLOCK_SIZE_RST;
            file_length_reg  <= FILE_LENGTH_RST;
            total_blocks_reg <= TOTAL_BLOCKS_RST;
            block_index_reg  <= IDX_W'(1);
            left_block_reg   <= '0;
            left_file_reg    <= FILE_LENGTH_RST;
        end else begin
            if (cfg_wr) begin
                case (cfg_index)
                    REG_BLOCK_SIZE:   block_size_reg   <= cfg_data[BSIZE_W-1:0];
                    REG_FILE_LENGTH:  file_length_reg  <= cfg_data;
                    REG_TOTAL_BLOCKS: total_blocks_reg <= cfg_data;
                    default:          ;
                endcase
            end
            block_index_reg <= block_index_next;
            left_block_reg  <= left_block_next;
            left_file_reg   <= left_file_next;
        end
    end

    mlfe_emitter u_emitter (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .load       (accept),
        .item       (item),
        .take_ready (take_ready),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast)
    );

endmodule

// ===== design/mlfe_emitter.sv =====
// Symbol emitter: holds one item, walks its symbols one beat per cycle when
// unstalled, keeps the running level, drives the output reg. Uses mlfe_pkg.
module mlfe_emitter
    import mlfe_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        load,        // item accepted this cycle
    input  item_t       item,
    output logic        take_ready,  // can accept an item this cycle
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,     // [8:0] level, [17:9] symbol, rest zero
    output logic        m_tlast
);

    logic                work_vld_reg, work_vld_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    item_t               item_reg;
    logic [LEVEL_W-1:0]  level_reg, level_next;
    logic                m_valid_reg;
    logic [LEVEL_W-1:0]  m_level_reg;
    logic [SYM_W-1:0]    m_sym_reg;
    logic                m_last_reg;

    logic                advance;
    logic                is_last;
    logic [STEP_W-1:0]   hdr_pos;
    logic [31:0]         hdr_word;
    logic [7:0]          hdr_byte;
    logic [SYM_W-1:0]    sym;
    logic [LEVEL_W:0]    sum;

    assign advance = work_vld_reg && (!m_valid_reg || m_tready);
    assign is_last = (step_reg == STEP_END) || ((step_reg == STEP_DATA) && !item_reg.ends);
    assign take_ready = !work_vld_reg || (advance && is_last);

    // Header word and byte lane for the current step
    assign hdr_pos = step_reg - STEP_TOT0;
    always_comb begin
        case (step_reg) inside
            [STEP_TOT0:STEP_TOT3]: hdr_word = item_reg.total;
            [STEP_IDX0:STEP_IDX3]: hdr_word = item_reg.index;
            [STEP_SZ0:STEP_SZ3]:   hdr_word = {16'd0, item_reg.size};
            default:               hdr_word = '0;
        endcase
    end
    assign hdr_byte = hdr_word[{hdr_pos[1:0], 3'b000} +: 8];

    // Symbol for the current step
    always_comb begin
        case (step_reg) inside
            STEP_START:            sym = SYM_START;
            [STEP_TOT0:STEP_SZ3]:  sym = {1'b0, hdr_byte} + 9'd1;
            STEP_DATA:             sym = {1'b0, item_reg.data} + 9'd1;
            STEP_END:              sym = SYM_END;
            default:               sym = SYM_END;
        endcase
    end

    // Level update: both terms are below the modulus, one subtract is enough
    assign sum = {1'b0, level_reg} + {1'b0, sym};
    always_comb begin
        level_next = level_reg;
        if (advance) begin
            if (sum >= MODULUS) begin
                level_next = LEVEL_W'(sum - MODULUS);
            end else begin
                level_next = sum[LEVEL_W-1:0];
            end
        end
    end

    // Step sequencing
    always_comb begin
        work_vld_next = work_vld_reg;
        step_next     = step_reg;
        if (advance) begin
            if (is_last) begin
                work_vld_next = 1'b0;
            end else begin
                step_next = step_reg + 4'd1;
            end
        end
        if (load) begin
            work_vld_next = 1'b1;
            step_next     = item.hdr ? STEP_START : STEP_DATA;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            work_vld_reg <= 1'b0;
            step_reg     <= STEP_START;
            level_reg    <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            work_vld_reg <= work_vld_next;
            step_reg     <= step_next;
            level_reg    <= level_next;
            if (advance) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (load) begin
            item_reg <= item;
        end
        if (advance) begin
            m_level_reg <= level_next;
            m_sym_reg   <= sym;
            m_last_reg  <= is_last;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {6'd0, m_sym_reg, m_level_reg};
    assign m_tlast  = m_last_reg;

endmodule

// ===== design/mlfe_checker.sv =====
// Port-level checks for the modular level frame encoder, bound to the top.
// Uses mlfe_pkg for symbol codes and the level range.
module mlfe_checker
    import mlfe_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata,
    input logic        m_tlast
);

    // A stalled output beat holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("output beat changed while stalled");

    // Level and symbol stay in range
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ({1'b0, m_tdata[8:0]} <= MAX_LEVEL) && (m_tdata[17:9] != '0)
                     && (m_tdata[17:9] <= SYM_END))
        else $error("level or symbol out of range");

    // A start marker never closes a run
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[17:9] == SYM_START) |-> !m_tlast)
        else $error("start marker flagged last");

    // An end marker always closes a run
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[17:9] == SYM_END) |-> m_tlast)
        else $error("end marker not flagged last");

endmodule

bind modular_level_frame_encoder_top mlfe_checker u_mlfe_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

// ===== dv/mlfe_frame_checker.sv =====
// Scoreboard for the modular level frame encoder. It watches the input, output
// and register channels, rebuilds the framing and the running level, and checks every output beat.
// Depends on mlfe_pkg.
module mlfe_frame_checker
    import mlfe_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [7:0]           s_tdata,   // [7:0] data_byte
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [23:0]          m_tdata,   // [8:0] level, [17:9] symbol, rest zero
    input  logic                 m_tlast,   // last_of_run
    input  logic                 cfg_valid,
    input  logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_DAT_W-1:0] cfg_data,
    output int                   mismatch_count,
    output int                   beats_pending
);

    typedef struct packed {
        logic [LEVEL_W-1:0] level;
        logic [SYM_W-1:0]   symbol;
        logic               last;
    } level_beat_t;

    localparam int PAD_LSB = LEVEL_W + SYM_W;

    // Register shadows
    logic [BSIZE_W-1:0] block_size_q;
    logic [FLEN_W-1:0]  file_length_q;
    logic [IDX_W-1:0]   total_blocks_q;

    // Framing state
    logic [LEVEL_W-1:0] level_q;
    logic [IDX_W-1:0]   block_num;
    logic [BSIZE_W-1:0] block_left;
    logic [FLEN_W-1:0]  file_left;

    // Beats of the byte being framed, then the FIFO of outstanding beats
    level_beat_t run_beats [0:14];
    int          run_len;
    level_beat_t expected_beats [$];
    int          fail_total;

    function void restart_pass();
        block_num  = 1;
        block_left = '0;
        file_left  = (file_length_q == 0) ? 1 : file_length_q;
    endfunction

    // Level moves modulo MODULUS; the sum never reaches twice the modulus
    function void add_symbol(input logic [SYM_W-1:0] sym);
        logic [LEVEL_W:0] sum;
        sum = {1'b0, level_q} + {1'b0, sym};
        if (sum >= MODULUS) begin
            sum = sum - MODULUS;
        end
        level_q = sum[LEVEL_W-1:0];
        run_beats[run_len].level  = level_q;
        run_beats[run_len].symbol = sym;
        run_beats[run_len].last   = 1'b0;
        run_len++;
    endfunction

    // Header word: four bytes, low byte first, each plus one
    function void add_word(input logic [31:0] word);
        for (int i = 0; i < 4; i++) begin
            add_symbol({1'b0, word[8*i +: 8]} + 9'd1);
        end
    endfunction

    function void frame_byte(input logic [7:0] data);
        logic [FLEN_W-1:0] eff_block;
        logic [FLEN_W-1:0] chunk;
        run_len = 0;
        if (file_left == 0) begin
            restart_pass();
        end
        // Open a block: start marker, total, block number, size
        if (block_left == 0) begin
            eff_block = (block_size_q == 0) ? 1 : {16'b0, block_size_q};
            chunk     = (file_left < eff_block) ? file_left : eff_block;
            add_symbol(SYM_START);
            add_word(total_blocks_q);
            add_word(block_num);
            add_word(chunk);
            block_left = chunk[BSIZE_W-1:0];
        end
        add_symbol({1'b0, data} + 9'd1);
        block_left = block_left - 1'b1;
        file_left  = file_left - 1'b1;
        // Close the block; the pass wraps after its last block
        if (block_left == 0) begin
            add_symbol(SYM_END);
            block_num = block_num + 1'b1;
            if (file_left == 0) begin
                restart_pass();
            end
        end
        for (int i = 0; i < run_len; i++) begin
            run_beats[i].last = (i == run_len - 1);
            expected_beats.push_back(run_beats[i]);
        end
    endfunction

    function void apply_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] data);
        case (idx)
            REG_BLOCK_SIZE: begin
                block_size_q = data[BSIZE_W-1:0];
                restart_pass();
            end
            REG_FILE_LENGTH: begin
                file_length_q = data[FLEN_W-1:0];
                restart_pass();
            end
            REG_TOTAL_BLOCKS: begin
                total_blocks_q = data[IDX_W-1:0];
                restart_pass();
            end
            default: begin
                // unused index: no effect at all
            end
        endcase
    endfunction

    function void check_beat();
        level_beat_t want;
        if (expected_beats.size() == 0) begin
            if (fail_total < 10) begin
                $display("unexpected beat: level %0d symbol %0d last %0b",
                         m_tdata[LEVEL_W-1:0], m_tdata[LEVEL_W +: SYM_W], m_tlast);
            end
            fail_total++;
            return;
        end
        want = expected_beats.pop_front();
        if (m_tdata[LEVEL_W-1:0] !== want.level || m_tdata[LEVEL_W +: SYM_W] !== want.symbol
                || m_tlast !== want.last || m_tdata[23:PAD_LSB] !== '0) begin
            if (fail_total < 10) begin
                $display("beat mismatch: expected level %0d symbol %0d last %0b pad 0, got level %0d symbol %0d last %0b pad %0h",
                         want.level, want.symbol, want.last, m_tdata[LEVEL_W-1:0],
                         m_tdata[LEVEL_W +: SYM_W], m_tlast, m_tdata[23:PAD_LSB]);
            end
            fail_total++;
        end
    endfunction

    // Sample all three channels at the clock edge
    always @(posedge aclk) begin
        if (!aresetn) begin
            block_size_q   = BLOCK_SIZE_RST;
            file_length_q  = FILE_LENGTH_RST;
            total_blocks_q = TOTAL_BLOCKS_RST;
            level_q        = '0;
            restart_pass();
            expected_beats.delete();
            fail_total     = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                check_beat();
            end
            if (cfg_valid && cfg_ready) begin
                apply_write(cfg_index, cfg_data);
            end
            if (s_tvalid && s_tready) begin
                frame_byte(s_tdata);
            end
        end
        mismatch_count <= fail_total;
        beats_pending  <= expected_beats.size();
    end

endmodule

// ===== dv/tb_modular_level_frame_encoder_top.sv =====
// Testbench top for the modular level frame encoder: clock, reset, byte and
// register stimulus, output back-pressure and the verdict. Uses mlfe_pkg and
// mlfe_frame_checker beside the DUT.
module tb_modular_level_frame_encoder_top;
    import mlfe_pkg::*;

    localparam int CYCLE_LIMIT = 600000;
    localparam int ITEM_TARGET = 210;
    localparam int HOLD_AFTER  = 40;   // bytes sent before the long output hold
    localparam int LONG_HOLD   = 300;
    localparam int SETTLE      = 40;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [7:0]           s_tdata;    // [7:0] data_byte
    logic                 m_tvalid;
    logic                 m_tready;
    logic [23:0]          m_tdata;    // [8:0] level, [17:9] symbol, rest zero
    logic                 m_tlast;    // last_of_run
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DAT_W-1:0] cfg_data;

    int   mismatch_count;
    int   beats_pending;
    int   bytes_sent  = 0;
    int   cycle_count = 0;
    logic no_gaps     = 1'b0;
    logic long_hold_done = 1'b0;

    modular_level_frame_encoder_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    mlfe_frame_checker u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tlast        (m_tlast),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .mismatch_count (mismatch_count),
        .beats_pending  (beats_pending)
    );

    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    // Watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // Idle lengths: mostly none or short, now and then long
    function automatic int pick_idle();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 40);
    endfunction

    // One byte beat; tvalid stays high between back-to-back bytes
    task automatic send_byte(input logic [7:0] data);
        int gap;
        gap = no_gaps ? 0 : pick_idle();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= data;
        do @(posedge aclk); while (!s_tready);
        bytes_sent++;
    endtask

    // Stop offering bytes and wait until every expected beat is out
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (beats_pending != 0) @(posedge aclk);
    endtask

    // Raises the write valid only; callers lower it after the last write
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
    endtask

    task automatic configure(input logic [15:0] bsize, input logic [31:0] flen,
                             input logic [31:0] tblocks);
        write_reg(REG_BLOCK_SIZE, {16'b0, bsize});
        write_reg(REG_FILE_LENGTH, flen);
        write_reg(REG_TOTAL_BLOCKS, tblocks);
        cfg_valid <= 1'b0;
    endtask

    // Output back-pressure, with one long hold while bytes keep coming
    initial begin
        int ready_len;
        int stall;
        m_tready = 1'b0;
        while (aresetn !== 1'b1) @(posedge aclk);
        forever begin
            if (!long_hold_done && bytes_sent >= HOLD_AFTER && s_tvalid) begin
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
                long_hold_done = 1'b1;
            end
            case ($urandom_range(0, 9))
                0:       ready_len = $urandom_range(100, 200);
                1, 2:    ready_len = $urandom_range(10, 60);
                default: ready_len = $urandom_range(1, 4);
            endcase
            m_tready <= 1'b1;
            repeat (ready_len) @(posedge aclk);
            stall = pick_idle();
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
        end
    end

    // Stimulus
    initial begin
        logic [15:0] bsize;
        logic [31:0] flen;
        logic [31:0] tblocks;
        longint      bs_eff;
        longint      fl_eff;
        int          count;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        cfg_valid = 1'b0;
        cfg_index = REG_BLOCK_SIZE;
        cfg_data  = '0;
        aresetn   = 1'b0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset settings: one long block opens; byte extremes
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'h5A);
        send_byte(8'hA5);
        drain();

        // Zero block size and zero file length act as one
        configure(16'd0, 32'd0, 32'd0);
        send_byte(8'hFF);
        send_byte(8'h00);
        drain();

        // Short blocks, short last block, announced total deliberately wrong
        configure(16'd2, 32'd5, 32'hFFFF_FFFF);
        send_byte(8'h01);
        send_byte(8'h80);
        send_byte(8'h7F);
        drain();

        // Unused index changes nothing; the pass wraps and stops mid-block
        write_reg(REG_UNUSED, 32'hFFFF_FFFF);
        cfg_valid <= 1'b0;
        send_byte(8'hFE);
        send_byte(8'h02);
        send_byte(8'hC3);
        drain();

        // Largest sizes; the writes land mid-block and restart the pass
        configure(16'hFFFF, 32'hFFFF_FFFF, 32'h8000_0000);
        send_byte(8'h3C);
        send_byte(8'hFF);
        send_byte(8'h00);
        drain();

        // Random phases: mostly small sizes so blocks close and passes wrap
        while (bytes_sent < ITEM_TARGET) begin
            if ($urandom_range(0, 4) != 0) begin
                case ($urandom_range(0, 9))
                    0:       bsize = 16'd0;
                    1:       bsize = 16'hFFFF;
                    2:       bsize = 16'($urandom_range(0, 65535));
                    default: bsize = 16'($urandom_range(1, 6));
                endcase
                case ($urandom_range(0, 9))
                    0:       flen = 32'd0;
                    1:       flen = 32'hFFFF_FFFF;
                    2:       flen = $urandom;
                    default: flen = $urandom_range(1, 20);
                endcase
                bs_eff = (bsize == 0) ? 1 : bsize;
                fl_eff = (flen == 0) ? 1 : flen;
                case ($urandom_range(0, 7))
                    0:       tblocks = 32'd0;
                    1:       tblocks = 32'hFFFF_FFFF;
                    2, 3:    tblocks = $urandom;
                    default: tblocks = 32'((fl_eff + bs_eff - 1) / bs_eff);
                endcase
                configure(bsize, flen, tblocks);
                if ($urandom_range(0, 3) == 0) begin
                    @(posedge aclk);
                    write_reg(REG_UNUSED, $urandom);
                    cfg_valid <= 1'b0;
                end
            end
            no_gaps = ($urandom_range(0, 3) == 0);
            count   = $urandom_range(6, 24);
            repeat (count) send_byte(8'($urandom_range(0, 255)));
            no_gaps = 1'b0;
            drain();
        end

        repeat (SETTLE) @(posedge aclk);
        if (mismatch_count == 0 && beats_pending == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
